@@ design/qau_pkg.sv @@
`default_nettype none
package qau_pkg;

  localparam int DW        = 32;             // Q3.28 operand and result width
  localparam int FRAC_BITS = 28;
  localparam int PW        = 2 * DW;         // one full product
  localparam int SW        = PW + 2;         // sum of four products
  localparam int RW        = SW - FRAC_BITS; // rounded product sum
  localparam int LW        = DW + 1;         // add, subtract, negate
  localparam int NC        = 4;              // quaternion components
  localparam int NT        = 4;              // product terms per component

  localparam logic [2:0] ACT_ADD   = 3'd0;
  localparam logic [2:0] ACT_SUB   = 3'd1;
  localparam logic [2:0] ACT_MUL   = 3'd2;
  localparam logic [2:0] ACT_SCALE = 3'd3;
  localparam logic [2:0] ACT_CONJ  = 3'd4;

  localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (FRAC_BITS - 1);

  // hamilton product: component c, term j is s[c][j] * t[c][j]
  localparam logic [1:0] S_IDX [NC][NT] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };
  localparam logic [1:0] T_IDX [NC][NT] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };
  // bit j set: term j is subtracted
  localparam logic [NT-1:0] NEG_MASK [NC] = '{
    4'b1110, 4'b1000, 4'b1000, 4'b1000
  };

  typedef struct packed {
    logic       valid;
    logic [2:0] action;
  } qau_ctl_t;

endpackage
`default_nettype wire

@@ design/qau_mul_stage.sv @@
`default_nettype none
module qau_mul_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [2:0]                    action,
  input  wire logic signed [qau_pkg::DW-1:0] a [qau_pkg::NC],
  input  wire logic signed [qau_pkg::DW-1:0] b [qau_pkg::NC],
  input  wire logic signed [qau_pkg::DW-1:0] factor,
  output qau_pkg::qau_ctl_t                  ctl_o,
  output logic signed [qau_pkg::PW-1:0]      prod_o [qau_pkg::NC][qau_pkg::NT],
  output logic signed [qau_pkg::LW-1:0]      lin_o [qau_pkg::NC]
);
  import qau_pkg::*;

  logic                 valid_r;
  logic [2:0]           action_r;
  logic signed [PW-1:0] prod_r [NC][NT];
  logic signed [PW-1:0] prod_nxt [NC][NT];
  logic signed [LW-1:0] lin_r [NC];
  logic signed [LW-1:0] lin_nxt [NC];
  logic signed [DW-1:0] s_op [NC][NT];
  logic signed [DW-1:0] t_op [NC][NT];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      for (int j = 0; j < NT; j++) begin
        s_op[c][j] = a[S_IDX[c][j]];
        t_op[c][j] = b[T_IDX[c][j]];
      end
      // scaling borrows the first multiplier of each component
      if (action == ACT_SCALE) begin
        s_op[c][0] = a[c];
        t_op[c][0] = factor;
      end
      for (int j = 0; j < NT; j++) begin
        prod_nxt[c][j] = PW'(s_op[c][j]) * PW'(t_op[c][j]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      case (action)
        ACT_ADD: begin
          lin_nxt[c] = LW'(a[c]) + LW'(b[c]);
        end
        ACT_SUB: begin
          lin_nxt[c] = LW'(a[c]) - LW'(b[c]);
        end
        ACT_CONJ: begin
          lin_nxt[c] = (c == 0) ? LW'(a[c]) : -LW'(a[c]);
        end
        default: begin
          lin_nxt[c] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      action_r <= action;
      prod_r   <= prod_nxt;
      lin_r    <= lin_nxt;
    end
  end

  assign ctl_o  = '{valid: valid_r, action: action_r};
  assign prod_o = prod_r;
  assign lin_o  = lin_r;

endmodule
`default_nettype wire

@@ design/qau_sum_stage.sv @@
`default_nettype none
module qau_sum_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire qau_pkg::qau_ctl_t             ctl_i,
  input  wire logic signed [qau_pkg::PW-1:0] prod_i [qau_pkg::NC][qau_pkg::NT],
  input  wire logic signed [qau_pkg::LW-1:0] lin_i [qau_pkg::NC],
  output logic                               valid_o,
  output logic signed [qau_pkg::RW-1:0]      val_o [qau_pkg::NC]
);
  import qau_pkg::*;

  logic                 valid_r;
  logic signed [RW-1:0] val_r [NC];
  logic signed [RW-1:0] val_nxt [NC];
  logic signed [SW-1:0] term [NC][NT];
  logic signed [SW-1:0] acc [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      for (int j = 0; j < NT; j++) begin
        if (ctl_i.action == ACT_SCALE && j != 0) begin
          term[c][j] = '0;
        end else if (ctl_i.action == ACT_MUL && NEG_MASK[c][j]) begin
          term[c][j] = -SW'(prod_i[c][j]);
        end else begin
          term[c][j] = SW'(prod_i[c][j]);
        end
      end
      // exact sum, round half up, then drop the fraction
      acc[c] = term[c][0] + term[c][1] + term[c][2] + term[c][3] + ROUND_HALF;
      if (ctl_i.action == ACT_MUL || ctl_i.action == ACT_SCALE) begin
        val_nxt[c] = acc[c][SW-1:FRAC_BITS];
      end else begin
        val_nxt[c] = RW'(lin_i[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
    end
  end

  assign valid_o = valid_r;
  assign val_o   = val_r;

`ifndef SYNTH
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !en |=> valid_r && $stable(val_r[0]) && $stable(val_r[3]))
    else $error("sum stage lost a held beat");
`endif

endmodule
`default_nettype wire

@@ design/qau_sat_stage.sv @@
`default_nettype none
module qau_sat_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          valid_i,
  input  wire logic signed [qau_pkg::RW-1:0] val_i [qau_pkg::NC],
  output logic                               en_o,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [qau_pkg::DW-1:0]      out_r_w,
  output logic signed [qau_pkg::DW-1:0]      out_r_x,
  output logic signed [qau_pkg::DW-1:0]      out_r_y,
  output logic signed [qau_pkg::DW-1:0]      out_r_z,
  output logic                               out_saturated
);
  import qau_pkg::*;

  localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

  logic                 valid_r;
  logic signed [DW-1:0] res_r [NC];
  logic signed [DW-1:0] res_nxt [NC];
  logic                 sat_r;
  logic                 sat_nxt;
  logic [NC-1:0]        clip;

  assign en_o = !valid_r || !out_stall;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      // in range only if the bits above the result all copy its sign
      clip[c] = (val_i[c][RW-1:DW-1] != {(RW-DW+1){val_i[c][DW-1]}});
      if (!clip[c]) begin
        res_nxt[c] = val_i[c][DW-1:0];
      end else if (val_i[c][RW-1]) begin
        res_nxt[c] = MIN_VAL;
      end else begin
        res_nxt[c] = MAX_VAL;
      end
    end
    sat_nxt = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_r_w       = res_r[0];
  assign out_r_x       = res_r[1];
  assign out_r_y       = res_r[2];
  assign out_r_z       = res_r[3];
  assign out_saturated = sat_r;

`ifndef SYNTH
  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_r_w == MAX_VAL || out_r_w == MIN_VAL || out_r_x == MAX_VAL || out_r_x == MIN_VAL ||
      out_r_y == MAX_VAL || out_r_y == MIN_VAL || out_r_z == MAX_VAL || out_r_z == MIN_VAL)
    else $error("saturated flag without a clipped component");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

@@ design/quaternion_arithmetic_unit.sv @@
`default_nettype none
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    in_action, in_a_*, in_b_*, in_factor
// out      output     out_valid / out_stall  out_r_w/x/y/z, out_saturated
//
// one beat in per cycle while in_stall is low, one result beat per input beat, in order
// three registered stages: multiplier bank, product sum and rounding, saturation
// rst_n is synchronous; it empties all three stages
// each stage holds only while the next one is full and stalled, so bubbles
// close up and in_stall rises only when every stage holds a beat
module quaternion_arithmetic_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_action,
  input  wire logic signed [qau_pkg::DW-1:0] in_a_w,
  input  wire logic signed [qau_pkg::DW-1:0] in_a_x,
  input  wire logic signed [qau_pkg::DW-1:0] in_a_y,
  input  wire logic signed [qau_pkg::DW-1:0] in_a_z,
  input  wire logic signed [qau_pkg::DW-1:0] in_b_w,
  input  wire logic signed [qau_pkg::DW-1:0] in_b_x,
  input  wire logic signed [qau_pkg::DW-1:0] in_b_y,
  input  wire logic signed [qau_pkg::DW-1:0] in_b_z,
  input  wire logic signed [qau_pkg::DW-1:0] in_factor,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [qau_pkg::DW-1:0]      out_r_w,
  output logic signed [qau_pkg::DW-1:0]      out_r_x,
  output logic signed [qau_pkg::DW-1:0]      out_r_y,
  output logic signed [qau_pkg::DW-1:0]      out_r_z,
  output logic                               out_saturated
);
  import qau_pkg::*;

  logic signed [DW-1:0] a [NC];
  logic signed [DW-1:0] b [NC];
  qau_ctl_t             ctl1;
  logic signed [PW-1:0] prod1 [NC][NT];
  logic signed [LW-1:0] lin1 [NC];
  logic                 valid2;
  logic signed [RW-1:0] val2 [NC];
  logic                 en1;
  logic                 en2;
  logic                 en3;

  assign a[0] = in_a_w;
  assign a[1] = in_a_x;
  assign a[2] = in_a_y;
  assign a[3] = in_a_z;
  assign b[0] = in_b_w;
  assign b[1] = in_b_x;
  assign b[2] = in_b_y;
  assign b[3] = in_b_z;

  assign en2      = !valid2 || en3;
  assign en1      = !ctl1.valid || en2;
  assign in_stall = !en1;

  qau_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en1),
    .in_valid (in_valid),
    .action   (in_action),
    .a        (a),
    .b        (b),
    .factor   (in_factor),
    .ctl_o    (ctl1),
    .prod_o   (prod1),
    .lin_o    (lin1)
  );

  qau_sum_stage u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en2),
    .ctl_i   (ctl1),
    .prod_i  (prod1),
    .lin_i   (lin1),
    .valid_o (valid2),
    .val_o   (val2)
  );

  qau_sat_stage u_sat (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (valid2),
    .val_i         (val2),
    .en_o          (en3),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_r_w       (out_r_w),
    .out_r_x       (out_r_x),
    .out_r_y       (out_r_y),
    .out_r_z       (out_r_z),
    .out_saturated (out_saturated)
  );

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ctl1.valid && valid2 && out_valid && out_stall)
    else $error("input stalled while the pipeline has room");
`endif

endmodule
`default_nettype wire
